// ----- sv/imfc_pkg.sv -----
// shared constants and field widths for the ising metropolis flip core
`timescale 1ns / 1ps

package imfc_pkg;

    // default lattice geometry and random number precision
    localparam int LATTICE_SIDE_DEF = 128;
    localparam int RANDOM_BITS_DEF  = 16;

    // configuration register reset values
    localparam logic [15:0] ACCEPT_ONE_RST = 16'd20900;
    localparam logic [15:0] ACCEPT_TWO_RST = 16'd6665;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_ONE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_TWO = 1'b1;

    // input item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_FLIP = 1'b1;

    // input and result field widths
    localparam int SITE_W       = 7;
    localparam int RANDOM_IN_W  = 16;
    localparam int MAG_W        = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 24;

endpackage

// ----- sv/imfc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module imfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/imfc_sub_unit.sv -----
// shared subtract and compare unit used by the sequencer
`timescale 1ns / 1ps

module imfc_sub_unit #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    logic [WIDTH:0] full;

    // borrow set means a is below b
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[WIDTH-1:0];
    assign borrow = full[WIDTH];

endmodule

// ----- sv/ising_metropolis_flip_core.sv -----
// ising lattice with single spin metropolis updates, top level
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-------------------------------------------------
// s_*     | in  | s_tvalid/s_tready  | tuser: func; tdata: row, col, load_spin, random
// m_*     | out | m_tvalid/m_tready  | tdata: flipped, spin_after, magnetization
// cfg_*   | in  | cfg_we             | cfg_index selects threshold, cfg_wdata value
//
// a flip item goes from accept to the next accept through two site reduction steps,
// three row reads of the lattice ram, one energy compare, one row write back, one
// result load and the idle state; a load item skips the down row read and the
// compare
// each site reduction step takes LATTICE_SIDE off its field until the field is smaller
// after reset a clearing pass writes every row and sets every spin to +1; no beat
// is taken meanwhile, configuration writes are taken as ever
// a result waits in the output register while m_tready is low; the next item is
// accepted only after its result has been loaded
`timescale 1ns / 1ps

module ising_metropolis_flip_core
    import imfc_pkg::*;
#(
    parameter int LATTICE_SIDE = LATTICE_SIDE_DEF,
    parameter int RANDOM_BITS  = RANDOM_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // slave side
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // site_row, site_col, load_spin, random_fraction
    input  logic                   s_tuser,   // func
    // master side
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // flipped, spin_after, magnetization
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ROW_W   = $clog2(LATTICE_SIDE);
    localparam int SITES   = LATTICE_SIDE * LATTICE_SIDE;
    localparam int MOM_W   = ($clog2(SITES) + 2 > 17) ? $clog2(SITES) + 2 : 17;
    localparam int THR_W   = (RANDOM_BITS > 16) ? RANDOM_BITS : 16;
    localparam int RND_W   = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;
    localparam int SIDE_W  = $clog2(LATTICE_SIDE + 1);
    localparam int UNIT_W  = (THR_W > SIDE_W) ? THR_W : SIDE_W;
    localparam int THR_SHL = (RANDOM_BITS >= 16) ? RANDOM_BITS - 16 : 0;
    localparam int THR_SHR = (RANDOM_BITS >= 16) ? 0 : 16 - RANDOM_BITS;

    localparam logic [ROW_W-1:0] SIDE_LAST = ROW_W'(LATTICE_SIDE - 1);
    localparam logic signed [MOM_W-1:0] MOM_RST = MOM_W'(SITES);
    localparam logic signed [MOM_W-1:0] MAG_HI  = MOM_W'(32767);
    localparam logic signed [MOM_W-1:0] MAG_LO  = MOM_W'(-32768);
    localparam logic signed [MOM_W-1:0] MOM_TWO = MOM_W'(2);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RED_ROW,
        ST_RED_COL,
        ST_RD_C,
        ST_RD_U,
        ST_RD_D,
        ST_CMP,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [15:0]              level_one_reg;
    logic [15:0]              level_two_reg;
    logic [ROW_W-1:0]         clr_cnt_reg;
    logic                     func_reg;
    logic [SITE_W-1:0]        row_w_reg;
    logic [SITE_W-1:0]        col_w_reg;
    logic                     load_reg;
    logic [RND_W-1:0]         rnd_reg;
    logic [LATTICE_SIDE-1:0]  center_row_reg;
    logic                     up_bit_reg;
    logic                     accept_reg;
    logic                     flipped_reg;
    logic                     spin_after_reg;
    logic signed [MOM_W-1:0]  moment_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic [ROW_W-1:0]         row_idx;
    logic [ROW_W-1:0]         col_idx;
    logic [ROW_W-1:0]         row_up;
    logic [ROW_W-1:0]         row_down;
    logic [ROW_W-1:0]         col_left;
    logic [ROW_W-1:0]         col_right;
    logic                     spin_c;
    logic                     spin_down;
    logic [2:0]               same_cnt;
    logic [THR_W-1:0]         thr_sel;
    logic                     spin_new;
    logic signed [MOM_W-1:0]  mag_sat;

    logic [UNIT_W-1:0]        unit_a;
    logic [UNIT_W-1:0]        unit_b;
    logic [UNIT_W-1:0]        unit_diff;
    logic                     unit_borrow;

    logic                     ram_we;
    logic [ROW_W-1:0]         ram_waddr;
    logic [LATTICE_SIDE-1:0]  ram_wdata;
    logic                     ram_re;
    logic [ROW_W-1:0]         ram_raddr;
    logic [LATTICE_SIDE-1:0]  ram_rdata;

    // site indices and wrapped neighbours
    assign row_idx   = ROW_W'(row_w_reg);
    assign col_idx   = ROW_W'(col_w_reg);
    assign row_up    = (row_idx == '0) ? SIDE_LAST : row_idx - 1'b1;
    assign row_down  = (row_idx == SIDE_LAST) ? '0 : row_idx + 1'b1;
    assign col_left  = (col_idx == '0) ? SIDE_LAST : col_idx - 1'b1;
    assign col_right = (col_idx == SIDE_LAST) ? '0 : col_idx + 1'b1;

    // local energy as count of neighbours aligned with the centre spin
    assign spin_c    = center_row_reg[col_idx];
    assign spin_down = ram_rdata[col_idx];
    assign same_cnt  = 3'(up_bit_reg == spin_c) + 3'(spin_down == spin_c)
                     + 3'(center_row_reg[col_left] == spin_c)
                     + 3'(center_row_reg[col_right] == spin_c);

    // threshold for energy -4 when all four agree, else for energy -2
    always_comb
    begin
        if (same_cnt == 3'd4)
        begin
            thr_sel = (THR_W'(level_two_reg) << THR_SHL) >> THR_SHR;
        end
        else
        begin
            thr_sel = (THR_W'(level_one_reg) << THR_SHL) >> THR_SHR;
        end
    end

    // shared unit operand selection
    always_comb
    begin
        unique case (state_reg)
            ST_RED_ROW:
            begin
                unit_a = UNIT_W'(row_w_reg);
                unit_b = UNIT_W'(LATTICE_SIDE);
            end
            ST_RED_COL:
            begin
                unit_a = UNIT_W'(col_w_reg);
                unit_b = UNIT_W'(LATTICE_SIDE);
            end
            default:
            begin
                unit_a = UNIT_W'(rnd_reg);
                unit_b = UNIT_W'(thr_sel);
            end
        endcase
    end

    imfc_sub_unit #(
        .WIDTH (UNIT_W)
    ) u_sub (
        .a      (unit_a),
        .b      (unit_b),
        .diff   (unit_diff),
        .borrow (unit_borrow)
    );

    // new centre spin and saturated magnetization
    assign spin_new = (func_reg == FUNC_FLIP) ? (spin_c ^ accept_reg) : load_reg;
    assign mag_sat  = (moment_reg > MAG_HI) ? MAG_HI :
                      (moment_reg < MAG_LO) ? MAG_LO : moment_reg;

    // lattice ram control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_idx;
        ram_wdata = center_row_reg;
        ram_re    = 1'b0;
        ram_raddr = row_idx;
        ram_wdata[col_idx] = spin_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '1;
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
            end
            ST_RD_C:
            begin
                ram_re = 1'b1;
            end
            ST_RD_U:
            begin
                ram_re    = 1'b1;
                ram_raddr = row_up;
            end
            ST_RD_D:
            begin
                ram_re    = 1'b1;
                ram_raddr = row_down;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    imfc_ram #(
        .WIDTH (LATTICE_SIDE),
        .DEPTH (LATTICE_SIDE)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_one_reg <= ACCEPT_ONE_RST;
            level_two_reg <= ACCEPT_TWO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEPT_ONE: level_one_reg <= cfg_wdata;
                CFG_ACCEPT_TWO: level_two_reg <= cfg_wdata;
                default:        level_one_reg <= level_one_reg;
            endcase
        end
    end

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            moment_reg   <= MOM_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // result taken while no new one is being loaded
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SIDE_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg  <= s_tuser;
                        row_w_reg <= s_tdata[6:0];
                        col_w_reg <= s_tdata[13:7];
                        load_reg  <= s_tdata[14];
                        rnd_reg   <= s_tdata[15 +: RND_W];
                        state_reg <= ST_RED_ROW;
                    end
                end
                ST_RED_ROW:
                begin
                    if (unit_borrow)
                    begin
                        state_reg <= ST_RED_COL;
                    end
                    else
                    begin
                        row_w_reg <= unit_diff[SITE_W-1:0];
                    end
                end
                ST_RED_COL:
                begin
                    if (unit_borrow)
                    begin
                        state_reg <= ST_RD_C;
                    end
                    else
                    begin
                        col_w_reg <= unit_diff[SITE_W-1:0];
                    end
                end
                ST_RD_C:
                begin
                    state_reg <= ST_RD_U;
                end
                ST_RD_U:
                begin
                    center_row_reg <= ram_rdata;
                    state_reg      <= (func_reg == FUNC_FLIP) ? ST_RD_D : ST_WRITE;
                end
                ST_RD_D:
                begin
                    up_bit_reg <= ram_rdata[col_idx];
                    state_reg  <= ST_CMP;
                end
                ST_CMP:
                begin
                    accept_reg <= (same_cnt < 3'd3) || unit_borrow;
                    state_reg  <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    flipped_reg    <= (func_reg == FUNC_FLIP) && accept_reg;
                    spin_after_reg <= spin_new;
                    if (spin_new != spin_c)
                    begin
                        moment_reg <= spin_new ? moment_reg + MOM_TWO : moment_reg - MOM_TWO;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {6'd0, mag_sat[MAG_W-1:0], spin_after_reg,
                                         flipped_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/imfc_checker.sv -----
// port level checks for the ising metropolis flip core, bound to the top level
`timescale 1ns / 1ps

module imfc_checker
    import imfc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // the clearing pass keeps the input closed right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input open during lattice clearing");

    // a new result appears only when the sequencer was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without an item in work");

endmodule

bind ising_metropolis_flip_core imfc_checker u_imfc_checker (.*);
